// ===== hdl/sit_pkg.sv =====
// Package for the symbol intern table: sizes, request and status codes, states.
package sit_pkg;
  localparam int unsigned MaxSymbols = 64;
  localparam int unsigned MaxSymLen = 32;
  localparam int unsigned IdxW = $clog2(MaxSymbols);
  localparam int unsigned CntW = $clog2(MaxSymbols + 1);
  localparam int unsigned PosW = $clog2(MaxSymLen);
  localparam int unsigned LenW = $clog2(MaxSymLen + 1);
  localparam int unsigned AddrW = IdxW + PosW;
  localparam int unsigned CharDepth = MaxSymbols * MaxSymLen;

  typedef enum logic [1:0] {
    ReqIntern = 2'd0,
    ReqFind = 2'd1,
    ReqFetch = 2'd2,
    ReqClear = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StLong = 3'd1,
    StFull = 3'd2,
    StNotFound = 3'd3,
    StBadIndex = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SCmpLen,
    SCmpRd,
    SCmpChk,
    SCopy,
    SFetchRd,
    SFetchOut
  } state_e;
endpackage

// ===== hdl/symbol_intern_table.sv =====
// Symbol intern table: linear search and fetch over a character memory.
// A char item without last only extends the pending run; intern/find compare each
// entry by length, then char by char, and intern copies a new run into the table.
// Flow: one request at a time; busy is high until the result run ends.
// Reset: entry count, pending run and sequencer clear; memories keep contents.
// Results appear with valid_o for one cycle each; the receiver cannot stall.
module symbol_intern_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_byte_i,
  input  logic        char_none_i,
  input  logic        char_last_i,
  input  logic [15:0] fetch_index_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [5:0]  found_index_o,
  output logic [7:0]  out_byte_o,
  output logic        out_none_o,
  output logic        out_last_o
);
  logic [7:0] chars_mem [sit_pkg::CharDepth];
  logic [sit_pkg::LenW-1:0] len_mem [sit_pkg::MaxSymbols];
  logic [7:0] pend_mem [sit_pkg::MaxSymLen];

  sit_pkg::state_e state_q, state_d;
  logic [sit_pkg::CntW-1:0] count_q;
  logic [sit_pkg::LenW-1:0] plen_q;
  logic povf_q;
  logic is_intern_q;
  logic [sit_pkg::CntW-1:0] ent_q;
  logic [sit_pkg::LenW-1:0] pos_q;
  logic [sit_pkg::LenW-1:0] elen_q;
  logic [7:0] crd_q, prd_q;

  logic acc, ch_acc, done_acc;
  logic [sit_pkg::AddrW-1:0] addr;

  assign busy = (state_q != sit_pkg::SIdle);
  assign acc = start && !busy;
  assign ch_acc = acc && (req_type_i[1] == 1'b0);
  assign done_acc = ch_acc && char_last_i;
  assign addr = {ent_q[sit_pkg::IdxW-1:0], pos_q[sit_pkg::PosW-1:0]};

  always_ff @(posedge clk_i) begin
    if (ch_acc && !char_none_i && plen_q < sit_pkg::LenW'(sit_pkg::MaxSymLen)) begin
      pend_mem[plen_q[sit_pkg::PosW-1:0]] <= char_byte_i;
    end
    if (state_q == sit_pkg::SCopy) begin
      if (pos_q < plen_q) begin
        chars_mem[addr] <= pend_mem[pos_q[sit_pkg::PosW-1:0]];
      end
    end
    if (state_q == sit_pkg::SCmpLen && is_intern_q && ent_q == count_q) begin
      len_mem[ent_q[sit_pkg::IdxW-1:0]] <= plen_q;
    end
    crd_q <= chars_mem[addr];
    prd_q <= pend_mem[pos_q[sit_pkg::PosW-1:0]];
    elen_q <= len_mem[ent_q[sit_pkg::IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sit_pkg::SIdle: begin
        if (acc) begin
          priority if (req_type_i == sit_pkg::ReqFetch) begin
            if (fetch_index_i < 16'(count_q)) state_d = sit_pkg::SFetchRd;
          end else if (done_acc) begin
            if (povf_q || char_none_i == 1'b0 && plen_q == sit_pkg::LenW'(sit_pkg::MaxSymLen)) begin
              state_d = sit_pkg::SIdle;
            end else if (req_type_i == sit_pkg::ReqIntern &&
                         count_q >= sit_pkg::CntW'(sit_pkg::MaxSymbols)) begin
              state_d = sit_pkg::SIdle;
            end else begin
              state_d = sit_pkg::SCmpLen;
            end
          end
        end
      end
      sit_pkg::SCmpLen: begin
        if (ent_q >= count_q) begin
          state_d = is_intern_q ? sit_pkg::SCopy : sit_pkg::SIdle;
        end else begin
          state_d = sit_pkg::SCmpRd;
        end
      end
      sit_pkg::SCmpRd: state_d = sit_pkg::SCmpChk;
      sit_pkg::SCmpChk: begin
        if (elen_q != plen_q) state_d = sit_pkg::SCmpLen;
        else if (pos_q >= plen_q) state_d = sit_pkg::SIdle;
        else if (crd_q != prd_q) state_d = sit_pkg::SCmpLen;
        else state_d = sit_pkg::SCmpRd;
      end
      sit_pkg::SCopy: begin
        if (pos_q >= plen_q) state_d = sit_pkg::SIdle;
      end
      sit_pkg::SFetchRd: state_d = sit_pkg::SFetchOut;
      sit_pkg::SFetchOut: begin
        if (elen_q == '0 || pos_q + 1'b1 >= elen_q) state_d = sit_pkg::SIdle;
        else state_d = sit_pkg::SFetchRd;
      end
      default: state_d = sit_pkg::SIdle;
    endcase
  end

  logic [sit_pkg::LenW-1:0] nlen;
  logic nfull;
  always_comb begin
    nlen = plen_q;
    if (ch_acc && !char_none_i && plen_q < sit_pkg::LenW'(sit_pkg::MaxSymLen)) begin
      nlen = plen_q + 1'b1;
    end
    nfull = ch_acc && !char_none_i && plen_q == sit_pkg::LenW'(sit_pkg::MaxSymLen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sit_pkg::SIdle;
      count_q <= '0;
      plen_q <= '0;
      povf_q <= 1'b0;
      is_intern_q <= 1'b0;
      ent_q <= '0;
      pos_q <= '0;
      valid_o <= 1'b0;
      status_o <= sit_pkg::StOk;
      found_index_o <= '0;
      out_byte_o <= '0;
      out_none_o <= 1'b1;
      out_last_o <= 1'b1;
    end else begin
      state_q <= state_d;
      valid_o <= 1'b0;
      status_o <= sit_pkg::StOk;
      found_index_o <= '0;
      out_byte_o <= '0;
      out_none_o <= 1'b1;
      out_last_o <= 1'b1;
      unique case (state_q)
        sit_pkg::SIdle: begin
          ent_q <= '0;
          pos_q <= '0;
          if (acc && req_type_i == sit_pkg::ReqClear) begin
            count_q <= '0;
            plen_q <= '0;
            povf_q <= 1'b0;
            valid_o <= 1'b1;
          end else if (acc && req_type_i == sit_pkg::ReqFetch) begin
            ent_q <= sit_pkg::CntW'(fetch_index_i[sit_pkg::IdxW-1:0]);
            if (fetch_index_i >= 16'(count_q)) begin
              valid_o <= 1'b1;
              status_o <= sit_pkg::StBadIndex;
            end
          end else if (ch_acc) begin
            plen_q <= nlen;
            povf_q <= povf_q | nfull;
            is_intern_q <= (req_type_i == sit_pkg::ReqIntern);
            if (char_last_i) begin
              if (povf_q || nfull) begin
                valid_o <= 1'b1;
                status_o <= req_type_i == sit_pkg::ReqIntern ? sit_pkg::StLong
                                                              : sit_pkg::StNotFound;
                plen_q <= '0;
                povf_q <= 1'b0;
              end else if (req_type_i == sit_pkg::ReqIntern &&
                           count_q >= sit_pkg::CntW'(sit_pkg::MaxSymbols)) begin
                valid_o <= 1'b1;
                status_o <= sit_pkg::StFull;
                plen_q <= '0;
              end
            end
          end
        end
        sit_pkg::SCmpLen: begin
          pos_q <= '0;
          if (ent_q >= count_q && !is_intern_q) begin
            valid_o <= 1'b1;
            status_o <= sit_pkg::StNotFound;
            plen_q <= '0;
          end
        end
        sit_pkg::SCmpRd: ;
        sit_pkg::SCmpChk: begin
          if (elen_q == plen_q && pos_q >= plen_q) begin
            valid_o <= 1'b1;
            found_index_o <= 6'(ent_q);
            plen_q <= '0;
          end else if (elen_q != plen_q || crd_q != prd_q) begin
            pos_q <= '0;
            ent_q <= ent_q + 1'b1;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        sit_pkg::SCopy: begin
          pos_q <= pos_q + 1'b1;
          if (pos_q >= plen_q) begin
            valid_o <= 1'b1;
            found_index_o <= 6'(ent_q);
            count_q <= count_q + 1'b1;
            plen_q <= '0;
          end
        end
        sit_pkg::SFetchRd: ;
        sit_pkg::SFetchOut: begin
          valid_o <= 1'b1;
          pos_q <= pos_q + 1'b1;
          if (elen_q != '0) begin
            out_byte_o <= crd_q;
            out_none_o <= 1'b0;
            out_last_o <= (pos_q + 1'b1 >= elen_q);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sit_pkg::CntW'(sit_pkg::MaxSymbols)) else $error("count overflow");
  a_plen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= sit_pkg::LenW'(sit_pkg::MaxSymLen)) else $error("pending overflow");
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_last_o && state_q != sit_pkg::SIdle |-> state_q != sit_pkg::SCmpRd)
    else $error("result during read");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i == sit_pkg::ReqClear |=> count_q == '0 && valid_o)
    else $error("clear failed");
`endif
endmodule

// ===== verif/tb_symbol_intern_table.sv =====
// Self-checking testbench for symbol_intern_table: random symbol requests against a table model.
module tb_symbol_intern_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 40000;

  typedef struct {
    sit_pkg::req_e kind;
    logic [7:0]  ch;
    logic        none;
    logic        last;
    logic [15:0] idx;
    bit          hold;
  } request_t;

  typedef struct {
    sit_pkg::status_e st;
    logic [5:0]  fidx;
    logic [7:0]  ch;
    logic        none;
    logic        last;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [7:0]  char_byte_i;
  logic        char_none_i;
  logic        char_last_i;
  logic [15:0] fetch_index_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [5:0]  found_index_o;
  logic [7:0]  out_byte_o;
  logic        out_none_o;
  logic        out_last_o;

  request_t requests[$];
  answer_t  answers[$];
  int       errors;
  int       gap_left;
  int       idle_cycles;

  logic [7:0] tbl_chars[sit_pkg::MaxSymbols][sit_pkg::MaxSymLen];
  int         tbl_len[sit_pkg::MaxSymbols];
  int         tbl_count;
  logic [7:0] run_chars[sit_pkg::MaxSymLen];
  int         run_len;
  bit         run_long;

  symbol_intern_table u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .char_byte_i, .char_none_i,
    .char_last_i, .fetch_index_i, .valid_o, .status_o, .found_index_o,
    .out_byte_o, .out_none_o, .out_last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_answer(sit_pkg::status_e st, int fidx, logic [7:0] ch, logic none,
                             logic last);
    answer_t a;
    a.st = st;
    a.fidx = 6'(fidx);
    a.ch = ch;
    a.none = none;
    a.last = last;
    answers.push_back(a);
  endtask

  function automatic bit lookup_run(output int where);
    bit hit;
    where = 0;
    for (int i = 0; i < tbl_count; i++) begin
      hit = (tbl_len[i] == run_len);
      for (int k = 0; k < run_len; k++)
        if (tbl_chars[i][k] != run_chars[k]) hit = 0;
      if (hit) begin
        where = i;
        return 1;
      end
    end
    return 0;
  endfunction

  task automatic predict_request(request_t r);
    int where;
    if (r.kind == sit_pkg::ReqFetch) begin
      if (r.idx >= tbl_count) begin
        push_answer(sit_pkg::StBadIndex, 0, 8'h00, 1'b1, 1'b1);
      end else if (tbl_len[r.idx] == 0) begin
        push_answer(sit_pkg::StOk, 0, 8'h00, 1'b1, 1'b1);
      end else begin
        for (int k = 0; k < tbl_len[r.idx]; k++)
          push_answer(sit_pkg::StOk, 0, tbl_chars[r.idx][k], 1'b0,
                      k + 1 == tbl_len[r.idx]);
      end
    end else if (r.kind == sit_pkg::ReqClear) begin
      tbl_count = 0;
      run_len = 0;
      run_long = 0;
      push_answer(sit_pkg::StOk, 0, 8'h00, 1'b1, 1'b1);
    end else begin
      if (!r.none) begin
        if (run_len < sit_pkg::MaxSymLen) begin
          run_chars[run_len] = r.ch;
          run_len++;
        end else begin
          run_long = 1;
        end
      end
      if (r.last) begin
        if (r.kind == sit_pkg::ReqIntern) begin
          if (run_long) begin
            push_answer(sit_pkg::StLong, 0, 8'h00, 1'b1, 1'b1);
          end else if (tbl_count >= sit_pkg::MaxSymbols) begin
            push_answer(sit_pkg::StFull, 0, 8'h00, 1'b1, 1'b1);
          end else if (lookup_run(where)) begin
            push_answer(sit_pkg::StOk, where, 8'h00, 1'b1, 1'b1);
          end else begin
            for (int k = 0; k < run_len; k++) tbl_chars[tbl_count][k] = run_chars[k];
            tbl_len[tbl_count] = run_len;
            push_answer(sit_pkg::StOk, tbl_count, 8'h00, 1'b1, 1'b1);
            tbl_count++;
          end
        end else if (!run_long && lookup_run(where)) begin
          push_answer(sit_pkg::StOk, where, 8'h00, 1'b1, 1'b1);
        end else begin
          push_answer(sit_pkg::StNotFound, 0, 8'h00, 1'b1, 1'b1);
        end
        run_len = 0;
        run_long = 0;
      end
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  task automatic add(sit_pkg::req_e kind, logic [7:0] ch, logic none, logic last,
                     logic [15:0] idx, bit hold);
    request_t r;
    r.kind = kind;
    r.ch = ch;
    r.none = none;
    r.last = last;
    r.idx = idx;
    r.hold = hold;
    requests.push_back(r);
  endtask

  task automatic add_fetch(int idx);
    add(sit_pkg::ReqFetch, 8'($urandom), 1'($urandom), 1'($urandom), 16'(idx), 0);
  endtask

  // wide: full byte range; otherwise a four-letter alphabet so symbols collide
  task automatic add_symbol(sit_pkg::req_e kind, int n, bit wide, bit noisy, bit hold);
    logic [7:0] alpha[4] = '{8'h00, 8'h41, 8'h42, 8'hff};
    logic [7:0] ch;
    sit_pkg::req_e k;
    if (n == 0) begin
      add(kind, 8'($urandom), 1'b1, 1'b1, 16'($urandom), hold);
      return;
    end
    for (int i = 0; i < n; i++) begin
      ch = wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)];
      k = (noisy && i + 1 < n) ? sit_pkg::req_e'($urandom_range(0, 1)) : kind;
      if (noisy && $urandom_range(0, 3) == 0)
        add(k, 8'($urandom), 1'b1, 1'b0, 16'($urandom), 0);
      add(k, ch, 1'b0, i + 1 == n, 16'($urandom), hold && i == 0);
    end
  endtask

  task automatic build_stimulus();
    int op;
    int n;
    bit filled;
    add(sit_pkg::ReqClear, 8'h00, 1'b0, 1'b0, 16'h0000, 0);
    add_symbol(sit_pkg::ReqIntern, 0, 0, 0, 0);
    add_symbol(sit_pkg::ReqFind, 0, 0, 0, 0);
    add_fetch(0);
    add_fetch(1);
    add_fetch(65535);
    add(sit_pkg::ReqIntern, 8'h00, 1'b0, 1'b0, 16'h0000, 0);
    add(sit_pkg::ReqIntern, 8'hff, 1'b0, 1'b1, 16'hffff, 0);
    add(sit_pkg::ReqIntern, 8'h00, 1'b0, 1'b0, 16'h0000, 0);
    add(sit_pkg::ReqIntern, 8'hff, 1'b0, 1'b1, 16'hffff, 0);
    add(sit_pkg::ReqFind, 8'h00, 1'b0, 1'b0, 16'h0000, 0);
    add(sit_pkg::ReqFind, 8'hff, 1'b0, 1'b1, 16'h0000, 0);
    add_fetch(1);
    add_symbol(sit_pkg::ReqIntern, sit_pkg::MaxSymLen, 1, 0, 0);
    add_fetch(2);
    add_symbol(sit_pkg::ReqIntern, sit_pkg::MaxSymLen + 1, 1, 0, 0);
    add_symbol(sit_pkg::ReqFind, sit_pkg::MaxSymLen + 2, 0, 0, 0);
    add(sit_pkg::ReqIntern, 8'h41, 1'b0, 1'b0, 16'h0000, 0);
    add_fetch(1);
    add(sit_pkg::ReqIntern, 8'h42, 1'b1, 1'b0, 16'h0000, 0);
    add(sit_pkg::ReqFind, 8'h42, 1'b0, 1'b1, 16'h0000, 0);
    add(sit_pkg::ReqFind, 8'h41, 1'b0, 1'b0, 16'h0000, 0);
    add(sit_pkg::ReqClear, 8'h00, 1'b0, 1'b0, 16'h0000, 0);
    add_symbol(sit_pkg::ReqFind, 1, 0, 0, 0);
    filled = 0;
    while (requests.size() < 410) begin
      op = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                     : $urandom_range(5, sit_pkg::MaxSymLen + 3);
      if (!filled && requests.size() > 180) begin
        filled = 1;
        add(sit_pkg::ReqClear, 8'h00, 1'b0, 1'b0, 16'h0000, 1);
        for (int i = 0; i < sit_pkg::MaxSymbols + 2; i++) begin
          add(sit_pkg::ReqIntern, 8'(i), 1'b0, 1'b0, 16'($urandom), 0);
          add(sit_pkg::ReqIntern, 8'($urandom), 1'b0, 1'b1, 16'($urandom), 0);
        end
        add_symbol(sit_pkg::ReqIntern, 0, 0, 0, 0);
        add_symbol(sit_pkg::ReqFind, 2, 1, 0, 0);
        add_fetch(sit_pkg::MaxSymbols - 1);
        add_fetch(sit_pkg::MaxSymbols);
      end else if (op < 40) begin
        add_symbol(sit_pkg::ReqIntern, n, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 5) == 0, $urandom_range(0, 40) == 0);
      end else if (op < 65) begin
        add_symbol(sit_pkg::ReqFind, n, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 5) == 0, 0);
      end else if (op < 87) begin
        add_fetch(($urandom_range(0, 4) != 0) ? $urandom_range(0, 70) : $urandom_range(0, 65535));
      end else if (op < 90) begin
        add(sit_pkg::ReqClear, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), 0);
      end else begin
        add(sit_pkg::req_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom), 1'b0,
            16'($urandom), 0);
        add_fetch($urandom_range(0, 70));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_type_i <= sit_pkg::ReqIntern;
      char_byte_i <= 8'h00;
      char_none_i <= 1'b0;
      char_last_i <= 1'b0;
      fetch_index_i <= 16'h0000;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_request(requests.pop_front());
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (requests.size() != 0 &&
                   !(requests[0].hold && (answers.size() != 0 || busy))) begin
        start <= 1'b1;
        req_type_i <= requests[0].kind;
        char_byte_i <= requests[0].ch;
        char_none_i <= requests[0].none;
        char_last_i <= requests[0].last;
        fetch_index_i <= requests[0].idx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && valid_o) begin
      if (answers.size() == 0) begin
        report("unexpected result status", status_o, 0);
      end else begin
        a = answers.pop_front();
        if (status_o != a.st) report("status", status_o, a.st);
        if (found_index_o != a.fidx) report("found_index", found_index_o, a.fidx);
        if (out_byte_o != a.ch) report("out_byte", out_byte_o, a.ch);
        if (out_none_o != a.none) report("out_none", out_none_o, a.none);
        if (out_last_o != a.last) report("out_last", out_last_o, a.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("symbol_intern_table verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    tbl_count = 0;
    run_len = 0;
    run_long = 0;
    rst_ni = 1'b0;
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (requests.size() != 0 || answers.size() != 0 || busy) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("symbol_intern_table verification clean");
    end else begin
      $display("symbol_intern_table verification failed");
    end
    $finish;
  end
endmodule
